[src/gts_pkg.sv]
// shared types and constants for the grid to triangle stream block
// no dependencies; imported by every module of the block
package gts_pkg;

  // fixed field widths
  localparam int COORD_W     = 32;
  localparam int CFG_COLS_W  = 11;
  localparam int CFG_ROWS_W  = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // default line store depth
  localparam int MAX_COLS_DEF = 1024;

  // register reset values
  localparam logic [CFG_COLS_W-1:0] NUM_COLS_RST = 11'd1024;
  localparam logic [CFG_ROWS_W-1:0] NUM_ROWS_RST = 16'd2;

  // register indexes, decoded from paddr[2]
  localparam logic REG_NUM_COLS = 1'b0;
  localparam logic REG_NUM_ROWS = 1'b1;

  // triangle kinds
  localparam logic TRI_UPPER = 1'b0;
  localparam logic TRI_LOWER = 1'b1;

  // one grid point
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      point_valid;
  } point_t;

  // one triangle
  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [COORD_W-1:0] vertex_a_z;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [COORD_W-1:0] vertex_b_z;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic signed [COORD_W-1:0] vertex_c_z;
    logic                      triangle_kind;
    logic                      last_of_run;
  } triangle_t;

  // configuration register contents
  typedef struct packed {
    logic [CFG_COLS_W-1:0] num_cols;
    logic [CFG_ROWS_W-1:0] num_rows;
  } cfg_t;

  // emitter status seen by the top level
  typedef struct packed {
    logic pending;
    logic upper_done;
  } emit_status_t;

endpackage

[src/gts_cfg_regs.sv]
// apb register file holding grid size (num_cols, num_rows)
// depends on gts_pkg
module gts_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gts_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output gts_pkg::cfg_t                  cfg_o
);
  import gts_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_cols <= NUM_COLS_RST;
      cfg_q.num_rows <= NUM_ROWS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_NUM_COLS: cfg_q.num_cols <= pwdata[CFG_COLS_W-1:0];
        REG_NUM_ROWS: cfg_q.num_rows <= pwdata[CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      REG_NUM_COLS: prdata = APB_DATA_W'(cfg_q.num_cols);
      REG_NUM_ROWS: prdata = APB_DATA_W'(cfg_q.num_rows);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/gts_line_store.sv]
// line store holding the previous row of points, read-before-write
// depends on gts_pkg
module gts_line_store #(
  parameter int MAX_COLS = gts_pkg::MAX_COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [$clog2(MAX_COLS)-1:0] addr_i,
  input  gts_pkg::point_t             wdata_i,
  output gts_pkg::point_t             rdata_o
);
  import gts_pkg::*;

  point_t mem [MAX_COLS];
  point_t rd_q;

  // old entry goes out, new point goes in at the same column
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q         <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rd_q;

endmodule

[src/gts_tri_emit.sv]
// holds one point with its neighbors and sends out its upper and lower triangles
// depends on gts_pkg
module gts_tri_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  gts_pkg::point_t        cur_i,
  input  logic                   cell_i,
  input  gts_pkg::point_t        up_i,
  output logic                   busy_o,
  output gts_pkg::emit_status_t  status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output gts_pkg::triangle_t     out_word_o
);
  import gts_pkg::*;

  logic      pend_q;
  logic      upper_done_q;
  logic      cell_q;
  point_t    cur_q;
  point_t    left_q;
  point_t    upleft_q;
  logic      out_valid_q;
  triangle_t out_q;

  logic      upper_ok;
  logic      lower_ok;
  logic      rem_upper;
  logic      out_free;
  logic      move;
  logic      done_now;
  triangle_t tri_d;

  // which triangles of the cell have all vertices valid
  assign upper_ok  = cell_q & upleft_q.point_valid & up_i.point_valid & left_q.point_valid;
  assign lower_ok  = cell_q & cur_q.point_valid & up_i.point_valid & left_q.point_valid;
  assign rem_upper = upper_ok & ~upper_done_q;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign move      = pend_q & out_free & (rem_upper | lower_ok);

  // item finishes when its last triangle moves out, or at once if it has none
  always_comb begin
    done_now = 1'b0;
    if (pend_q) begin
      if (rem_upper) begin
        done_now = out_free & ~lower_ok;
      end else if (lower_ok) begin
        done_now = out_free;
      end else begin
        done_now = 1'b1;
      end
    end
  end

  assign busy_o = pend_q & ~done_now;

  // triangle selection
  always_comb begin
    if (rem_upper) begin
      tri_d.vertex_a_x    = upleft_q.point_x;
      tri_d.vertex_a_y    = upleft_q.point_y;
      tri_d.vertex_a_z    = upleft_q.point_z;
      tri_d.vertex_b_x    = up_i.point_x;
      tri_d.vertex_b_y    = up_i.point_y;
      tri_d.vertex_b_z    = up_i.point_z;
      tri_d.vertex_c_x    = left_q.point_x;
      tri_d.vertex_c_y    = left_q.point_y;
      tri_d.vertex_c_z    = left_q.point_z;
      tri_d.triangle_kind = TRI_UPPER;
      tri_d.last_of_run   = ~lower_ok;
    end else begin
      tri_d.vertex_a_x    = left_q.point_x;
      tri_d.vertex_a_y    = left_q.point_y;
      tri_d.vertex_a_z    = left_q.point_z;
      tri_d.vertex_b_x    = up_i.point_x;
      tri_d.vertex_b_y    = up_i.point_y;
      tri_d.vertex_b_z    = up_i.point_z;
      tri_d.vertex_c_x    = cur_q.point_x;
      tri_d.vertex_c_y    = cur_q.point_y;
      tri_d.vertex_c_z    = cur_q.point_z;
      tri_d.triangle_kind = TRI_LOWER;
      tri_d.last_of_run   = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      upper_done_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept_i) begin
        pend_q       <= 1'b1;
        upper_done_q <= 1'b0;
      end else begin
        if (done_now) begin
          pend_q <= 1'b0;
        end
        if (move & rem_upper) begin
          upper_done_q <= 1'b1;
        end
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // point and neighbor registers, shifted on each accepted word
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cur_q    <= cur_i;
      left_q   <= cur_q;
      upleft_q <= up_i;
      cell_q   <= cell_i;
    end
    if (move) begin
      out_q <= tri_d;
    end
  end

  assign status_o.pending    = pend_q;
  assign status_o.upper_done = upper_done_q;
  assign out_valid_o         = out_valid_q;
  assign out_word_o          = out_q;

endmodule

[src/grid_to_triangle_stream_top.sv]
// top level of the grid to triangle stream block: position counters and wiring
// depends on gts_pkg, gts_cfg_regs, gts_line_store, gts_tri_emit
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o  | point_t (x, y, z, valid)
//   out     | output    | out_valid_o / out_stall_i| triangle_t
//   cfg     | input     | apb psel/penable/pready  | num_cols, num_rows
//
// a point yields zero, one or two triangles through a single output register;
// the input is held until the point's last triangle moves into that register,
// so a point whose cell gives two triangles holds it while its upper one goes out.
// the line store is read and written at the same column when a point is taken.
// reset clears the counters and handshake state; the line store is not cleared.
// a stall on the output backs up into in_stall_o once the emitter holds a point
// that still has a triangle to send.
module grid_to_triangle_stream_top #(
  parameter int MAX_COLS = gts_pkg::MAX_COLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gts_pkg::point_t                in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gts_pkg::triangle_t             out_word_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gts_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import gts_pkg::*;

  localparam int ColW = $clog2(MAX_COLS);
  localparam int LimW = (ColW + 1 > CFG_COLS_W) ? ColW + 1 : CFG_COLS_W;
  localparam int RowW = CFG_ROWS_W + 1;

  cfg_t              cfg;
  emit_status_t      emit_st;
  point_t            up;
  logic              in_fire;
  logic              busy;

  logic [ColW-1:0]   col_q;
  logic [ColW-1:0]   col_d;
  logic [ColW-1:0]   col_cur;
  logic [CFG_ROWS_W-1:0] row_q;
  logic [CFG_ROWS_W-1:0] row_d;
  logic [CFG_ROWS_W-1:0] row_cur;
  logic [LimW-1:0]   ncols;
  logic [LimW-1:0]   num_cols_ext;
  logic [LimW-1:0]   col_next;
  logic [CFG_ROWS_W-1:0] nrows;
  logic [RowW-1:0]   row_tmp;
  logic [RowW-1:0]   row_next;
  logic              cell_hit;

  // configuration registers
  gts_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i & ~busy;

  // effective grid size
  assign num_cols_ext = LimW'(cfg.num_cols);
  always_comb begin
    if (num_cols_ext < LimW'(2)) begin
      ncols = LimW'(2);
    end else if (num_cols_ext > LimW'(MAX_COLS)) begin
      ncols = LimW'(MAX_COLS);
    end else begin
      ncols = num_cols_ext;
    end
  end
  assign nrows = (cfg.num_rows < CFG_ROWS_W'(2)) ? CFG_ROWS_W'(2) : cfg.num_rows;

  // position of the incoming point, wrapping a counter left past a shrunk size
  always_comb begin
    if (LimW'(col_q) >= ncols) begin
      col_cur = '0;
      row_tmp = RowW'(row_q) + RowW'(1);
    end else begin
      col_cur = col_q;
      row_tmp = RowW'(row_q);
    end
    row_cur  = (row_tmp >= RowW'(nrows)) ? '0 : row_tmp[CFG_ROWS_W-1:0];
    cell_hit = (row_cur != '0) & (col_cur != '0);
    col_next = LimW'(col_cur) + LimW'(1);
    row_next = RowW'(row_cur) + RowW'(1);
    if (col_next >= ncols) begin
      col_d = '0;
      row_d = (row_next >= RowW'(nrows)) ? '0 : row_next[CFG_ROWS_W-1:0];
    end else begin
      col_d = col_next[ColW-1:0];
      row_d = row_cur;
    end
  end

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // previous row of points
  gts_line_store #(
    .MAX_COLS (MAX_COLS)
  ) u_line (
    .clk_i   (clk_i),
    .en_i    (in_fire),
    .addr_i  (col_cur),
    .wdata_i (in_word_i),
    .rdata_o (up)
  );

  // triangle emitter and output register
  gts_tri_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .cur_i       (in_word_i),
    .cell_i      (cell_hit),
    .up_i        (up),
    .busy_o      (busy),
    .status_o    (emit_st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  // an empty emitter never holds off the input
  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !emit_st.pending |-> !in_stall_o)
    else $error("input stalled with no point held");

  // an accepted point is held in the emitter on the next cycle
  a_fire_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> emit_st.pending)
    else $error("accepted point not held");

  // an upper triangle that is not last is followed at once by its lower one
  a_upper_then_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_word_o.triangle_kind == TRI_UPPER) &&
    !out_word_o.last_of_run
    |=> out_valid_o && (out_word_o.triangle_kind == TRI_LOWER))
    else $error("lower triangle missing after upper");

  // while a held point waits for its lower triangle the output word is valid
  a_upper_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_st.pending && emit_st.upper_done |-> out_valid_o)
    else $error("output empty after upper triangle of a held point");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for grid_to_triangle_stream_top: clocked driver, monitor and predictor
// depends on gts_pkg and the grid_to_triangle_stream_top rtl
module tb_top;
  import gts_pkg::*;

  localparam int                  LINE_DEPTH  = MAX_COLS_DEF;
  localparam int                  IDLE_LIMIT  = 5000;
  localparam int                  SETTLE_CYC  = 8;
  localparam int                  LONG_HOLD   = 300;
  localparam int                  RAND_ITEMS  = 1750;
  localparam logic signed [31:0]  C_MIN       = 32'h8000_0000;
  localparam logic signed [31:0]  C_MAX       = 32'h7fff_ffff;
  localparam logic signed [31:0]  C_ONES      = 32'hffff_ffff;
  localparam logic signed [31:0]  C_ONE       = 32'h0000_0001;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  point_t                in_word_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  triangle_t             out_word_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  grid_to_triangle_stream_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state: line store, neighbors, position and register copies
  point_t                grid_row [LINE_DEPTH];
  point_t                left_pt;
  point_t                upleft_pt;
  int                    col_pos;
  int                    row_pos;
  logic [CFG_COLS_W-1:0] cols_reg = NUM_COLS_RST;
  logic [CFG_ROWS_W-1:0] rows_reg = NUM_ROWS_RST;

  point_t    pending_points [$];
  triangle_t expected_tris [$];
  string     vertex_names [9] = '{"vertex_a_x", "vertex_a_y", "vertex_a_z",
                                  "vertex_b_x", "vertex_b_y", "vertex_b_z",
                                  "vertex_c_x", "vertex_c_y", "vertex_c_z"};

  bit in_fire;
  bit out_fire;
  int err_count   = 0;
  int idle_cycles = 0;
  int send_gap    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  bit hold_req     = 1'b0;
  bit hold_started = 1'b0;
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;

  // sizes as the block uses them
  function automatic int clamp_cols(input int v);
    if (v < 2) return 2;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return v;
  endfunction

  function automatic int clamp_rows(input int v);
    return (v < 2) ? 2 : v;
  endfunction

  function automatic triangle_t make_tri(input point_t a, input point_t b, input point_t c,
                                         input logic kind);
    triangle_t t;
    t.vertex_a_x    = a.point_x;
    t.vertex_a_y    = a.point_y;
    t.vertex_a_z    = a.point_z;
    t.vertex_b_x    = b.point_x;
    t.vertex_b_y    = b.point_y;
    t.vertex_b_z    = b.point_z;
    t.vertex_c_x    = c.point_x;
    t.vertex_c_y    = c.point_y;
    t.vertex_c_z    = c.point_z;
    t.triangle_kind = kind;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  // triangles completed by one grid point, then state update
  task automatic predict_triangles(input point_t cur);
    int        ncols;
    int        nrows;
    point_t    up_pt;
    triangle_t upper_tri;
    triangle_t lower_tri;
    bit        has_upper;
    bit        has_lower;
    ncols = clamp_cols(int'(cols_reg));
    nrows = clamp_rows(int'(rows_reg));
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= nrows) row_pos = 0;
    up_pt     = grid_row[col_pos];
    has_upper = 1'b0;
    has_lower = 1'b0;
    if (row_pos > 0 && col_pos > 0) begin
      has_upper = upleft_pt.point_valid && up_pt.point_valid && left_pt.point_valid;
      has_lower = cur.point_valid && up_pt.point_valid && left_pt.point_valid;
    end
    upper_tri = make_tri(upleft_pt, up_pt, left_pt, TRI_UPPER);
    lower_tri = make_tri(left_pt, up_pt, cur, TRI_LOWER);
    upper_tri.last_of_run = !has_lower;
    lower_tri.last_of_run = 1'b1;
    if (has_upper) expected_tris = {expected_tris, upper_tri};
    if (has_lower) expected_tris = {expected_tris, lower_tri};
    upleft_pt         = up_pt;
    grid_row[col_pos] = cur;
    left_pt           = cur;
    if (col_pos + 1 >= ncols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= nrows) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_triangle(input triangle_t exp_t, input triangle_t got_t);
    logic [31:0] exp_v [9];
    logic [31:0] got_v [9];
    exp_v = '{exp_t.vertex_a_x, exp_t.vertex_a_y, exp_t.vertex_a_z,
              exp_t.vertex_b_x, exp_t.vertex_b_y, exp_t.vertex_b_z,
              exp_t.vertex_c_x, exp_t.vertex_c_y, exp_t.vertex_c_z};
    got_v = '{got_t.vertex_a_x, got_t.vertex_a_y, got_t.vertex_a_z,
              got_t.vertex_b_x, got_t.vertex_b_y, got_t.vertex_b_z,
              got_t.vertex_c_x, got_t.vertex_c_y, got_t.vertex_c_z};
    for (int i = 0; i < 9; i++) begin
      if (exp_v[i] !== got_v[i]) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, vertex_names[i],
                 exp_v[i], got_v[i]);
        err_count++;
      end
    end
    if (exp_t.triangle_kind !== got_t.triangle_kind) begin
      $display("%0t: triangle_kind mismatch, expected %b, actual %b", $time,
               exp_t.triangle_kind, got_t.triangle_kind);
      err_count++;
    end
    if (exp_t.last_of_run !== got_t.last_of_run) begin
      $display("%0t: last_of_run mismatch, expected %b, actual %b", $time,
               exp_t.last_of_run, got_t.last_of_run);
      err_count++;
    end
  endtask

  // monitor: predict on accepted points, check accepted triangles, watchdog
  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) predict_triangles(in_word_i);
    if (out_fire) begin
      if (expected_tris.size() == 0) begin
        $display("%0t: unexpected triangle, expected none, actual %h", $time, out_word_o);
        err_count++;
      end else begin
        check_triangle(expected_tris.pop_front(), out_word_o);
      end
    end
    if (!rst_ni || in_fire || out_fire || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // gap lengths: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // point driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_fire) begin
        // stalled word stays put
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_points.size() > 0) begin
        in_valid_i <= 1'b1;
        in_word_i  <= pending_points.pop_front();
        send_gap   <= (tx_quiet || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // triangle receiver stall, with one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_left    <= LONG_HOLD;
        out_stall_i  <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
        stall_left  <= pick_gap() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // register write: setup then access cycle
  task automatic apb_write(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_NUM_COLS) cols_reg = value[CFG_COLS_W-1:0];
    else rows_reg = value[CFG_ROWS_W-1:0];
  endtask

  // wait until every point is taken and every triangle has come, then settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_points.size() != 0 || in_valid_i || expected_tris.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return C_ONES;
      3: return C_ONE;
      default: return '0;
    endcase
  endfunction

  task automatic push_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input logic v);
    point_t p;
    p.point_x     = x;
    p.point_y     = y;
    p.point_z     = z;
    p.point_valid = v;
    pending_points = {pending_points, p};
  endtask

  task automatic queue_points(input int count, input int valid_pct);
    for (int i = 0; i < count; i++)
      push_point(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 99) < valid_pct);
  endtask

  // points left before the position counters are back at row 0, column 0
  function automatic int points_to_grid_start();
    int ncols;
    int nrows;
    int c;
    int r;
    ncols = clamp_cols(int'(cols_reg));
    nrows = clamp_rows(int'(rows_reg));
    c = col_pos;
    r = row_pos;
    if (c >= ncols) begin
      c = 0;
      r++;
    end
    if (r >= nrows) r = 0;
    if (c == 0 && r == 0) return 0;
    return (nrows - r) * ncols - c;
  endfunction

  // one phase: new sizes, then a run of random points
  task automatic run_phase(input int cols_val, input int rows_val, input int count,
                           input int valid_pct, input bit long_hold);
    // widening a row needs a fresh grid so no unwritten line entry is read
    if (clamp_cols(cols_val) > clamp_cols(int'(cols_reg))) begin
      if (clamp_rows(int'(rows_reg)) > 8) apb_write(REG_NUM_ROWS, 2);
      queue_points(points_to_grid_start(), valid_pct);
      wait_drained();
    end
    apb_write(REG_NUM_COLS, cols_val);
    apb_write(REG_NUM_ROWS, rows_val);
    queue_points(count, valid_pct);
    if (long_hold) hold_req = 1'b1;
    wait_drained();
  endtask

  // stimulus
  initial begin
    int random_items;
    int phase_idx;
    int n_cols;
    int n_rows;
    int n_items;
    int r;
    left_pt   = '0;
    upleft_pt = '0;
    col_pos   = 0;
    row_pos   = 0;
    for (int i = 0; i < LINE_DEPTH; i++) grid_row[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed 4x3 grid: extreme coordinates, cells with both, upper only,
    // lower only and no triangles
    apb_write(REG_NUM_COLS, 4);
    apb_write(REG_NUM_ROWS, 3);
    push_point(C_MIN,  C_MAX,  '0,     1'b1);
    push_point(C_MAX,  C_MIN,  C_ONES, 1'b1);
    push_point('0,     C_ONES, C_MIN,  1'b1);
    push_point(C_ONE,  '0,     C_MAX,  1'b1);
    push_point(C_ONES, C_MAX,  C_MAX,  1'b1);
    push_point(C_MAX,  C_MAX,  C_MAX,  1'b0);
    push_point(C_MIN,  C_MIN,  C_MIN,  1'b1);
    push_point('0,     '0,     '0,     1'b1);
    push_point(C_MAX,  '0,     C_MIN,  1'b1);
    push_point(C_MIN,  C_ONES, C_ONE,  1'b1);
    push_point(C_ONES, C_ONES, C_ONES, 1'b1);
    push_point(C_MIN,  C_MAX,  C_MIN,  1'b1);
    wait_drained();

    // shrink the row while the column counter is past the new end
    apb_write(REG_NUM_COLS, 5);
    apb_write(REG_NUM_ROWS, 32'h0000_ffff);
    queue_points(8, 90);
    wait_drained();
    apb_write(REG_NUM_COLS, 3);
    queue_points(2, 90);
    wait_drained();
    // shrink the grid while the row counter is past the new end
    apb_write(REG_NUM_ROWS, 1);
    queue_points(2, 90);
    wait_drained();

    // random phases
    random_items = 0;
    phase_idx    = 0;
    while (random_items < RAND_ITEMS) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (phase_idx == 4) begin
        // widest row, entered through an out of range size
        n_cols  = 2047;
        n_rows  = 2;
        n_items = LINE_DEPTH + $urandom_range(40, 80);
      end else begin
        r = $urandom_range(0, 19);
        n_cols  = (r < 4) ? r : $urandom_range(2, 12);
        r = $urandom_range(0, 19);
        case (r)
          0: n_rows = 0;
          1: n_rows = 1;
          2: n_rows = 65535;
          3: n_rows = $urandom_range(2, 65535);
          default: n_rows = $urandom_range(2, 5);
        endcase
        n_items = (phase_idx == 1) ? 150 : $urandom_range(30, 120);
      end
      run_phase(n_cols, n_rows, n_items, ($urandom_range(0, 2) == 0) ? 50 : 90,
                phase_idx == 1);
      random_items += n_items;
      phase_idx++;
    end

    wait_drained();
    repeat (4 * SETTLE_CYC) @(posedge clk_i);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
